// ===== design/jbt_pkg.sv =====
package jbt_pkg;

    localparam logic [7:0] LEXEME_LIMIT = 8'd128;

    localparam logic [3:0] KIND_LBRACE  = 4'd0;
    localparam logic [3:0] KIND_RBRACE  = 4'd1;
    localparam logic [3:0] KIND_LBRACK  = 4'd2;
    localparam logic [3:0] KIND_RBRACK  = 4'd3;
    localparam logic [3:0] KIND_COMMA   = 4'd4;
    localparam logic [3:0] KIND_COLON   = 4'd5;
    localparam logic [3:0] KIND_STRING  = 4'd6;
    localparam logic [3:0] KIND_NUMBER  = 4'd7;
    localparam logic [3:0] KIND_TRUE    = 4'd8;
    localparam logic [3:0] KIND_FALSE   = 4'd9;
    localparam logic [3:0] KIND_NULL    = 4'd10;
    localparam logic [3:0] KIND_END     = 4'd11;
    localparam logic [3:0] KIND_BADCHAR = 4'd12;
    localparam logic [3:0] KIND_BADWORD = 4'd13;

    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_LOW_E  = 8'h65;
    localparam logic [7:0] CH_UP_E   = 8'h45;

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       token_end;
        logic       last;
    } res_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_num_more(input logic [7:0] c);
        return is_digit(c) || c == CH_DOT || c == CH_LOW_E || c == CH_UP_E
            || c == CH_PLUS || c == CH_MINUS;
    endfunction

    function automatic logic match_true(input logic [7:0] p, input logic [7:0] c);
        case (p)
            8'd0: return c == 8'h74;
            8'd1: return c == 8'h72;
            8'd2: return c == 8'h75;
            8'd3: return c == 8'h65;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic match_false(input logic [7:0] p, input logic [7:0] c);
        case (p)
            8'd0: return c == 8'h66;
            8'd1: return c == 8'h61;
            8'd2: return c == 8'h6C;
            8'd3: return c == 8'h73;
            8'd4: return c == 8'h65;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic match_null(input logic [7:0] p, input logic [7:0] c);
        case (p)
            8'd0: return c == 8'h6E;
            8'd1: return c == 8'h75;
            8'd2: return c == 8'h6C;
            8'd3: return c == 8'h6C;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [3:0] word_kind(input logic [7:0] cnt, input logic [2:0] alive);
        if (cnt == 8'd4 && alive[0]) begin
            return KIND_TRUE;
        end else if (cnt == 8'd5 && alive[1]) begin
            return KIND_FALSE;
        end else if (cnt == 8'd4 && alive[2]) begin
            return KIND_NULL;
        end
        return KIND_BADWORD;
    endfunction

endpackage

// ===== design/json_byte_tokenizer.sv =====
// Results of an accepted input transaction are written into the result queue and appear on the m_ side from there.
// Throughput: one byte per cycle while m_ready is high and no byte gives two results.
// A byte that gives two results fills the four-entry result queue faster than it
// drains, so s_ready drops until the queue holds at most one result again.
// Reset (aresetn, synchronous, active low) returns the lexer to idle and empties the queue.
module json_byte_tokenizer
    import jbt_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_text_byte,
    input  logic       s_end_of_input,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [3:0] m_kind,
    output logic [7:0] m_data_byte,
    output logic       m_byte_valid,
    output logic       m_token_end,
    output logic       m_last
);

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_STRING = 2'd1,
        MODE_NUMBER = 2'd2,
        MODE_WORD   = 2'd3
    } mode_t;

    mode_t      mode_reg, mode_next;
    logic [7:0] count_reg, count_next;
    logic [2:0] alive_reg, alive_next;

    res_t       fifo_reg [4];
    logic [1:0] head_reg, tail_reg;
    logic [2:0] fill_reg, fill_next;

    logic       accept, pop;
    logic [1:0] n_res;
    res_t       r0, r1;

    logic       st_emit;
    res_t       st_res;
    mode_t      st_mode;
    logic [7:0] st_count;
    logic [2:0] st_alive;

    logic [2:0] fed_alive;
    logic [7:0] fed_count;
    res_t       num_close, word_close_res;

    assign accept  = s_valid && s_ready;
    assign pop     = m_valid && m_ready;
    assign s_ready = (fill_reg <= 3'd1);
    assign m_valid = (fill_reg != 3'd0);

    assign m_kind       = fifo_reg[head_reg].kind;
    assign m_data_byte  = fifo_reg[head_reg].data_byte;
    assign m_byte_valid = fifo_reg[head_reg].byte_valid;
    assign m_token_end  = fifo_reg[head_reg].token_end;
    assign m_last       = fifo_reg[head_reg].last;

    // Token start for the incoming byte, as seen from the idle mode.
    always_comb begin
        st_emit  = 1'b0;
        st_res   = '{kind: KIND_BADCHAR, data_byte: s_text_byte, byte_valid: 1'b1,
                     token_end: 1'b1, last: 1'b0};
        st_mode  = MODE_IDLE;
        st_count = 8'd0;
        st_alive = 3'd0;
        if (is_space(s_text_byte)) begin
            st_emit = 1'b0;
        end else if (s_text_byte == CH_QUOTE) begin
            st_mode = MODE_STRING;
        end else if (s_text_byte == CH_LBRACE || s_text_byte == CH_RBRACE
                || s_text_byte == CH_LBRACK || s_text_byte == CH_RBRACK
                || s_text_byte == CH_COMMA || s_text_byte == CH_COLON) begin
            st_emit = 1'b1;
            st_res.data_byte  = 8'd0;
            st_res.byte_valid = 1'b0;
            case (s_text_byte)
                CH_LBRACE: st_res.kind = KIND_LBRACE;
                CH_RBRACE: st_res.kind = KIND_RBRACE;
                CH_LBRACK: st_res.kind = KIND_LBRACK;
                CH_RBRACK: st_res.kind = KIND_RBRACK;
                CH_COMMA:  st_res.kind = KIND_COMMA;
                default:   st_res.kind = KIND_COLON;
            endcase
        end else if (is_digit(s_text_byte) || s_text_byte == CH_MINUS
                || s_text_byte == CH_DOT) begin
            st_emit          = 1'b1;
            st_res.kind      = KIND_NUMBER;
            st_res.token_end = 1'b0;
            st_mode          = MODE_NUMBER;
            st_count         = 8'd1;
        end else if (is_alpha(s_text_byte)) begin
            st_mode  = MODE_WORD;
            st_count = 8'd1;
            st_alive = {match_null(8'd0, s_text_byte), match_false(8'd0, s_text_byte),
                        match_true(8'd0, s_text_byte)};
        end else begin
            st_emit = 1'b1;
        end
    end

    always_comb begin
        fed_alive = alive_reg & {match_null(count_reg, s_text_byte),
                                 match_false(count_reg, s_text_byte),
                                 match_true(count_reg, s_text_byte)};
        fed_count = count_reg + 8'd1;
        num_close = '{kind: KIND_NUMBER, data_byte: 8'd0, byte_valid: 1'b0,
                      token_end: 1'b1, last: 1'b0};
        word_close_res = '{kind: word_kind(count_reg, alive_reg), data_byte: 8'd0,
                           byte_valid: 1'b0, token_end: 1'b1, last: 1'b0};
    end

    always_comb begin
        r0         = st_res;
        r1         = st_res;
        n_res      = {1'b0, st_emit};
        mode_next  = st_mode;
        count_next = st_count;
        alive_next = st_alive;
        if (s_end_of_input) begin
            r1         = '{kind: KIND_END, data_byte: 8'd0, byte_valid: 1'b0,
                           token_end: 1'b1, last: 1'b0};
            mode_next  = MODE_IDLE;
            count_next = 8'd0;
            alive_next = 3'd0;
            case (mode_reg)
                MODE_STRING: begin
                    r0 = '{kind: KIND_STRING, data_byte: 8'd0, byte_valid: 1'b0,
                           token_end: 1'b1, last: 1'b0};
                    n_res = 2'd2;
                end
                MODE_NUMBER: begin
                    r0    = num_close;
                    n_res = 2'd2;
                end
                MODE_WORD: begin
                    r0    = word_close_res;
                    n_res = 2'd2;
                end
                default: begin
                    r0    = r1;
                    n_res = 2'd1;
                end
            endcase
        end else begin
            case (mode_reg)
                MODE_STRING: begin
                    n_res      = 2'd1;
                    count_next = count_reg;
                    alive_next = alive_reg;
                    if (s_text_byte == CH_QUOTE) begin
                        r0 = '{kind: KIND_STRING, data_byte: 8'd0, byte_valid: 1'b0,
                               token_end: 1'b1, last: 1'b0};
                        mode_next = MODE_IDLE;
                    end else begin
                        r0 = '{kind: KIND_STRING, data_byte: s_text_byte, byte_valid: 1'b1,
                               token_end: 1'b0, last: 1'b0};
                        mode_next = MODE_STRING;
                    end
                end
                MODE_NUMBER: begin
                    if (is_num_more(s_text_byte)) begin
                        r0 = '{kind: KIND_NUMBER, data_byte: s_text_byte, byte_valid: 1'b1,
                               token_end: 1'b0, last: 1'b0};
                        alive_next = alive_reg;
                        if (fed_count >= LEXEME_LIMIT) begin
                            r1         = num_close;
                            n_res      = 2'd2;
                            mode_next  = MODE_IDLE;
                            count_next = 8'd0;
                        end else begin
                            n_res      = 2'd1;
                            mode_next  = MODE_NUMBER;
                            count_next = fed_count;
                        end
                    end else begin
                        r0    = num_close;
                        r1    = st_res;
                        n_res = st_emit ? 2'd2 : 2'd1;
                    end
                end
                MODE_WORD: begin
                    if (is_alpha(s_text_byte)) begin
                        r0 = '{kind: word_kind(fed_count, fed_alive), data_byte: 8'd0,
                               byte_valid: 1'b0, token_end: 1'b1, last: 1'b0};
                        if (fed_count >= LEXEME_LIMIT) begin
                            n_res      = 2'd1;
                            mode_next  = MODE_IDLE;
                            count_next = 8'd0;
                            alive_next = 3'd0;
                        end else begin
                            n_res      = 2'd0;
                            mode_next  = MODE_WORD;
                            count_next = fed_count;
                            alive_next = fed_alive;
                        end
                    end else begin
                        r0    = word_close_res;
                        r1    = st_res;
                        n_res = st_emit ? 2'd2 : 2'd1;
                    end
                end
                default: begin
                    r0 = st_res;
                end
            endcase
        end
        if (n_res == 2'd1) begin
            r0.last = 1'b1;
        end
        if (n_res == 2'd2) begin
            r1.last = 1'b1;
        end
    end

    always_comb begin
        fill_next = fill_reg;
        if (accept) begin
            fill_next = fill_next + {1'b0, n_res};
        end
        if (pop) begin
            fill_next = fill_next - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            count_reg <= 8'd0;
            alive_reg <= 3'd0;
            head_reg  <= 2'd0;
            tail_reg  <= 2'd0;
            fill_reg  <= 3'd0;
        end else begin
            if (accept) begin
                mode_reg  <= mode_next;
                count_reg <= count_next;
                alive_reg <= alive_next;
                tail_reg  <= tail_reg + n_res;
            end
            if (pop) begin
                head_reg <= head_reg + 2'd1;
            end
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && n_res != 2'd0) begin
            fifo_reg[tail_reg] <= r0;
        end
        if (accept && n_res == 2'd2) begin
            fifo_reg[tail_reg + 2'd1] <= r1;
        end
    end

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= 3'd3)
        else $error("Result queue holds more than three entries.");

    a_end_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_end_of_input) |=> (mode_reg == MODE_IDLE && count_reg == 8'd0))
        else $error("Lexer is not idle after an end-of-input transaction.");

    a_open_token_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_token_end) |-> m_byte_valid)
        else $error("A result that does not end its token carries no byte.");

    a_lexeme_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_WORD || mode_reg == MODE_NUMBER)
            |-> (count_reg != 8'd0 && count_reg < LEXEME_LIMIT))
        else $error("Open number or word has a length outside its range.");

endmodule
